// File: rtl/bitmap_glyph_row_generator_macros.svh
// ----------------------------------------------------------------------------
// Glyph row generator assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_ROW_GENERATOR_MACROS_SVH
`define BITMAP_GLYPH_ROW_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BGRG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BGRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bgrg_pkg.sv
// ----------------------------------------------------------------------------
// Glyph row generator package
// Payload types, control/status structs, command and register codes.
// FONT_BYTES is taken as a power of two; font addresses wrap on its width.
// ----------------------------------------------------------------------------
package bgrg_pkg;

    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_MAX_HEIGHT = 16;
    localparam int DEF_FONT_BYTES = 4096;

    // hard ceiling of glyph width and height in the mask format
    localparam int DIM_MAX = 16;
    localparam int ROW_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;

    localparam logic [7:0] RST_FIRST_CODE   = 8'd32;
    localparam logic [7:0] RST_LAST_CODE    = 8'd126;
    localparam logic [4:0] RST_GLYPH_WIDTH  = 5'd8;
    localparam logic [4:0] RST_GLYPH_HEIGHT = 5'd8;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        load_addr;
        logic [7:0]         load_byte;
        logic [7:0]         char_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        fore_color;
        logic [15:0]        back_color;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic [15:0]        row_mask;
        logic [4:0]         row_width;
        logic [15:0]        set_color;
        logic [15:0]        clear_color;
        logic               window_mode;
        logic               glyph_valid;
        logic [4:0]         advance;
        logic               last_row;
    } t_out_item;

    typedef struct packed {
        logic             mem_wr;
        logic             capture;
        logic             post_bad;
        logic             issue;
        logic [ROW_W-1:0] row;
    } t_dp_cmd;

    typedef struct packed {
        logic s1_free;
        logic code_bad;
        logic row_last;
    } t_dp_status;

endpackage

// File: rtl/bgrg_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph row generator controller
// Takes requests, sends loads and draws to the datapath, issues glyph rows.
// ----------------------------------------------------------------------------
module bgrg_ctrl
    import bgrg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ROWS = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             in_ready;
    logic             accept;

    assign in_ready   = (r_state == ST_IDLE) && i_status.s1_free;
    assign o_in_stall = !in_ready;
    assign accept     = i_in_valid && in_ready;

    always_comb begin
        o_cmd.mem_wr   = accept && (i_in_cmd == CMD_LOAD);
        o_cmd.capture  = accept && (i_in_cmd == CMD_DRAW) && !i_status.code_bad;
        o_cmd.post_bad = accept && (i_in_cmd == CMD_DRAW) && i_status.code_bad;
        o_cmd.issue    = (r_state == ST_ROWS) && i_status.s1_free;
        o_cmd.row      = r_row;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_ROWS;
                    n_row   = '0;
                end
            end
            ST_ROWS: begin
                if (o_cmd.issue) begin
                    if (i_status.row_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

endmodule

// File: rtl/bgrg_dp.sv
// ----------------------------------------------------------------------------
// Glyph row generator datapath
// Configuration registers, font RAM with two read ports, row assembly and
// the output register.
// ----------------------------------------------------------------------------
module bgrg_dp
    import bgrg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FONT_BYTES = DEF_FONT_BYTES
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int AW     = $clog2(FONT_BYTES);
    localparam int SUM_W  = (AW > 14) ? AW : 14;
    localparam int W_LIM  = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
    localparam int H_LIM  = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;

    function automatic logic [4:0] clamp_dim(input logic [4:0] v, input logic [4:0] lim);
        logic [4:0] res;
        if (v == 5'd0) begin
            res = 5'd1;
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // configuration
    logic [7:0] r_first_code, r_last_code;
    logic [4:0] r_glyph_width, r_glyph_height;

    // draw context
    logic signed [15:0] r_x, r_y;
    logic [15:0]        r_fg, r_bg, r_wmask;
    logic               r_win, r_wide;
    logic [4:0]         r_w, r_h;
    logic [AW-1:0]      r_base;

    // font RAM and its read stage
    logic [7:0]       mem [FONT_BYTES];
    logic [7:0]       r_rd0, r_rd1;
    logic             r_s1_valid, r_s1_bad, r_s1_last;
    logic [ROW_W-1:0] r_s1_row;
    logic             s1_adv;

    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic [4:0]       w_eff, h_eff;
    logic [7:0]       code_idx;
    logic [12:0]      prod;
    logic [SUM_W-1:0] base_sum;
    logic [AW-1:0]    rd_addr0, rd_addr1, wr_addr;
    logic             row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code   <= RST_FIRST_CODE;
            r_last_code    <= RST_LAST_CODE;
            r_glyph_width  <= RST_GLYPH_WIDTH;
            r_glyph_height <= RST_GLYPH_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_CODE:   r_first_code   <= i_cfg_data;
                CFG_LAST_CODE:    r_last_code    <= i_cfg_data;
                CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[4:0];
                CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff    = clamp_dim(r_glyph_width, 5'(W_LIM));
    assign h_eff    = clamp_dim(r_glyph_height, 5'(H_LIM));
    assign code_idx = i_in_item.char_code - r_first_code;
    assign prod     = 13'(code_idx) * 13'(h_eff);
    // two byte planes per row once the glyph is wider than eight pixels
    assign base_sum = (w_eff > 5'd8) ? (SUM_W'(prod) << 1) : SUM_W'(prod);

    assign o_status.code_bad = (i_in_item.char_code < r_first_code) ||
                               (i_in_item.char_code > r_last_code);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x     <= i_in_item.pos_x;
            r_y     <= i_in_item.pos_y;
            r_fg    <= i_in_item.fore_color;
            r_bg    <= i_in_item.back_color;
            r_win   <= (i_in_item.fore_color == i_in_item.back_color);
            r_w     <= w_eff;
            r_h     <= h_eff;
            r_wide  <= (w_eff > 5'd8);
            r_wmask <= ~(16'hFFFF >> w_eff);
            r_base  <= AW'(base_sum);
        end
    end

    assign wr_addr  = AW'(SUM_W'(i_in_item.load_addr));
    assign rd_addr0 = r_base + AW'(i_cmd.row);
    assign rd_addr1 = r_base + AW'(r_h) + AW'(i_cmd.row);
    assign row_last = (5'(i_cmd.row) == (r_h - 5'd1));
    assign o_status.row_last = row_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[wr_addr] <= i_in_item.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd0 <= mem[rd_addr0];
            r_rd1 <= mem[rd_addr1];
        end
    end

    assign s1_adv           = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_status.s1_free = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.issue || i_cmd.post_bad) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue || i_cmd.post_bad) begin
            r_s1_bad  <= i_cmd.post_bad;
            r_s1_last <= i_cmd.post_bad || row_last;
            r_s1_row  <= i_cmd.row;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.last_row = r_s1_last;
        if (!r_s1_bad) begin
            n_out.row_x       = r_x;
            n_out.row_y       = r_y + 16'(r_s1_row);
            n_out.row_mask    = {r_rd0, (r_wide ? r_rd1 : 8'h00)} & r_wmask;
            n_out.row_width   = r_w;
            n_out.set_color   = r_fg;
            n_out.clear_color = r_bg;
            n_out.window_mode = r_win;
            n_out.glyph_valid = 1'b1;
            n_out.advance     = r_s1_last ? r_w : 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/bitmap_glyph_row_generator.sv
// ----------------------------------------------------------------------------
// Bitmap glyph row generator
// Fixed-width bitmap font character generator: loads font bytes and turns
// each in-range draw request into one pixel-mask result per glyph row.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_item
//   out     | output    | o_out_valid / i_out_stall | o_out_item
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A draw issues one glyph row per cycle while the read stage is free, both
// byte planes of a row read at once from the dual-read font RAM. A result
// passes the read stage and the output register after its row issues, or
// after its out-of-range request is taken.
// Output stall holds the row issue; new requests wait until all rows issue.
// Reset is synchronous; it restores the configuration, state and valid
// registers, the font RAM is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
`include "bitmap_glyph_row_generator_macros.svh"

module bitmap_glyph_row_generator
    import bgrg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FONT_BYTES = DEF_FONT_BYTES
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bgrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bgrg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FONT_BYTES (FONT_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    `BGRG_ASSERT_SAME(a_last_advance, i_clk, i_rst_n,
        o_out_valid && o_out_item.last_row && o_out_item.glyph_valid,
        o_out_item.advance == o_out_item.row_width,
        "last row advance differs from row width")

    `BGRG_ASSERT_SAME(a_mid_row, i_clk, i_rst_n,
        o_out_valid && !o_out_item.last_row,
        o_out_item.glyph_valid && (o_out_item.advance == 5'd0),
        "inner row is invalid or carries an advance")

    `BGRG_ASSERT_SAME(a_bad_code, i_clk, i_rst_n,
        o_out_valid && !o_out_item.glyph_valid,
        o_out_item.last_row && (o_out_item.row_mask == 16'h0000),
        "out-of-range result is not a lone empty row")

    `BGRG_ASSERT_NEXT(a_issue_busy, i_clk, i_rst_n,
        dp_cmd.issue && !dp_status.row_last,
        o_in_stall,
        "request taken while glyph rows remain")

endmodule
